@@ hdl/ugbt_pkg.sv @@
`default_nettype none
package ugbt_pkg;

   // grid geometry
   localparam int MAX_COLUMNS   = 32;
   localparam int MAX_ROWS      = 32;
   localparam int CELL_CAPACITY = 16;
   localparam int ID_BITS       = 16;

   localparam int COL_BITS  = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int CELL_BITS = COL_BITS + ROW_BITS;
   localparam int SLOT_BITS = $clog2(CELL_CAPACITY);
   localparam int CNT_BITS  = $clog2(CELL_CAPACITY + 1);
   localparam int MEM_BITS  = CELL_BITS + SLOT_BITS;
   localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;

   // field widths
   localparam int POS_BITS  = 24;
   localparam int SIZE_BITS = 16;
   localparam int DIM_BITS  = 6;
   localparam int DIV_CNT_BITS = $clog2(POS_BITS);

   // opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // status codes
   localparam logic [2:0] ST_ADDED       = 3'd0;
   localparam logic [2:0] ST_PRESENT     = 3'd1;
   localparam logic [2:0] ST_FULL        = 3'd2;
   localparam logic [2:0] ST_REMOVED     = 3'd3;
   localparam logic [2:0] ST_NOT_PRESENT = 3'd4;
   localparam logic [2:0] ST_LISTED      = 3'd5;
   localparam logic [2:0] ST_EMPTY       = 3'd6;
   localparam logic [2:0] ST_BAD_CELL    = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_CELL_SIZE   = 2'd0;
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       map_load;
      logic       cnt_load;
      logic       idx_clear;
      logic       scan_step;
      logic       shift_en;
      logic       app_wr;
      logic       cnt_wr;
      logic       cnt_inc;
      logic       clr_step;
      logic       emit;
      logic [2:0] emit_status;
      logic       emit_last;
   } ugbt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic div_done;
      logic bad_cell;
      logic n_zero;
      logic n_full;
      logic idx_last;
      logic found;
      logic out_free;
   } ugbt_sts_type;

endpackage
`default_nettype wire

@@ hdl/uniform_grid_bucket_table_core.sv @@
`default_nettype none
// Channel   Direction  Handshake              Contents
// req_      in         req_valid / req_stall  opcode, position, cell, entity id
// rsp_      out        rsp_valid / rsp_stall  member id, status, last, hit cell
// csr_      in         csr_valid / csr_ready  register index, write data
//
// After reset the per-cell counts are cleared, one cell a cycle, with req_stall
// high. One item is worked at a time. Add and query run a restoring divide
// (one quotient bit per cycle), then read the cell count and scan the cell's
// n slots. rsp_stall holds the scan of a query and every result.
module uniform_grid_bucket_table_core
   import ugbt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic signed [POS_BITS-1:0] req_pos_x,
   input  wire logic signed [POS_BITS-1:0] req_pos_y,
   input  wire logic [COL_BITS-1:0]        req_cell_col,
   input  wire logic [ROW_BITS-1:0]        req_cell_row,
   input  wire logic [ID_BITS-1:0]         req_entity_id,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [ID_BITS-1:0]              rsp_member_id,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_last,
   output logic [COL_BITS-1:0]             rsp_hit_col,
   output logic [ROW_BITS-1:0]             rsp_hit_row,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [SIZE_BITS-1:0]       csr_data
);

   ugbt_cmd_type cmd;
   ugbt_sts_type sts;

   ugbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   ugbt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_cell_col  (req_cell_col),
      .req_cell_row  (req_cell_row),
      .req_entity_id (req_entity_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_member_id (rsp_member_id),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .rsp_hit_col   (rsp_hit_col),
      .rsp_hit_row   (rsp_hit_row),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

endmodule
`default_nettype wire

@@ hdl/ugbt_ram.sv @@
`default_nettype none
module ugbt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/ugbt_datapath.sv @@
`default_nettype none
module ugbt_datapath
   import ugbt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ugbt_cmd_type               cmd,
   output ugbt_sts_type                    sts,
   input  wire logic signed [POS_BITS-1:0] req_pos_x,
   input  wire logic signed [POS_BITS-1:0] req_pos_y,
   input  wire logic [COL_BITS-1:0]        req_cell_col,
   input  wire logic [ROW_BITS-1:0]        req_cell_row,
   input  wire logic [ID_BITS-1:0]         req_entity_id,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [ID_BITS-1:0]              rsp_member_id,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_last,
   output logic [COL_BITS-1:0]             rsp_hit_col,
   output logic [ROW_BITS-1:0]             rsp_hit_row,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [SIZE_BITS-1:0]       csr_data
);

   // configuration
   logic [SIZE_BITS-1:0] cell_size_ff;
   logic [DIM_BITS-1:0]  grid_width_ff, grid_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff   <= SIZE_BITS'(8192);
         grid_width_ff  <= DIM_BITS'(MAX_COLUMNS);
         grid_height_ff <= DIM_BITS'(MAX_ROWS);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CELL_SIZE:   cell_size_ff   <= csr_data;
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[DIM_BITS-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective grid dimensions
   logic [DIM_BITS-1:0]  w_eff, h_eff, w_m1, h_m1;
   logic [SIZE_BITS-1:0] divisor;

   always_comb begin
      if (grid_width_ff == '0) w_eff = DIM_BITS'(1);
      else if (grid_width_ff > DIM_BITS'(MAX_COLUMNS)) w_eff = DIM_BITS'(MAX_COLUMNS);
      else w_eff = grid_width_ff;
      if (grid_height_ff == '0) h_eff = DIM_BITS'(1);
      else if (grid_height_ff > DIM_BITS'(MAX_ROWS)) h_eff = DIM_BITS'(MAX_ROWS);
      else h_eff = grid_height_ff;
      w_m1 = w_eff - DIM_BITS'(1);
      h_m1 = h_eff - DIM_BITS'(1);
      divisor = (cell_size_ff == '0) ? SIZE_BITS'(1) : cell_size_ff;
   end

   // request registers
   logic [ID_BITS-1:0]  id_ff;
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;

   // restoring dividers, one quotient bit per cycle on each axis;
   // a negative position always maps to column or row zero
   logic [POS_BITS-1:0]     dx_ff, dy_ff;
   logic [SIZE_BITS-1:0]    rx_ff, ry_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [SIZE_BITS:0]      rx_try, ry_try;
   logic                    qx_bit, qy_bit;

   always_comb begin
      rx_try = {rx_ff, dx_ff[POS_BITS-1]};
      ry_try = {ry_ff, dy_ff[POS_BITS-1]};
      qx_bit = rx_try >= {1'b0, divisor};
      qy_bit = ry_try >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff      <= req_pos_x[POS_BITS-1] ? '0 : req_pos_x;
         dy_ff      <= req_pos_y[POS_BITS-1] ? '0 : req_pos_y;
         rx_ff      <= '0;
         ry_ff      <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dx_ff      <= {dx_ff[POS_BITS-2:0], qx_bit};
         dy_ff      <= {dy_ff[POS_BITS-2:0], qy_bit};
         rx_ff      <= qx_bit ? SIZE_BITS'(rx_try - {1'b0, divisor}) : rx_try[SIZE_BITS-1:0];
         ry_ff      <= qy_bit ? SIZE_BITS'(ry_try - {1'b0, divisor}) : ry_try[SIZE_BITS-1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_BITS'(1);
      end
   end

   // cell coordinates: remove takes them directly, add and query clamp the quotient
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff  <= req_entity_id;
         col_ff <= req_cell_col;
         row_ff <= req_cell_row;
      end else if (cmd.map_load) begin
         col_ff <= (dx_ff > POS_BITS'(w_m1)) ? w_m1[COL_BITS-1:0] : dx_ff[COL_BITS-1:0];
         row_ff <= (dy_ff > POS_BITS'(h_m1)) ? h_m1[ROW_BITS-1:0] : dy_ff[ROW_BITS-1:0];
      end
   end

   logic [CELL_BITS-1:0] cell_addr;
   assign cell_addr = {row_ff, col_ff};

   // count store with clearing pass after reset
   logic [CELL_BITS-1:0] clr_ff;
   logic [CNT_BITS-1:0]  cnt_rdata, n_ff, cnt_wdata;
   logic                 cnt_we;
   logic [CELL_BITS-1:0] cnt_waddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + CELL_BITS'(1);
      end
   end

   always_comb begin
      cnt_we    = cmd.clr_step | cmd.cnt_wr;
      cnt_waddr = cmd.clr_step ? clr_ff : cell_addr;
      if (cmd.clr_step) cnt_wdata = '0;
      else if (cmd.cnt_inc) cnt_wdata = n_ff + CNT_BITS'(1);
      else cnt_wdata = n_ff - CNT_BITS'(1);
   end

   ugbt_ram #(.WIDTH(CNT_BITS), .DEPTH(NUM_CELLS)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cell_addr),
      .rdata (cnt_rdata)
   );

   // slot scan
   logic [SLOT_BITS-1:0] idx_ff, idx_m1;
   logic                 found_ff;
   logic [ID_BITS-1:0]   mem_rdata;
   logic                 match;

   assign idx_m1 = idx_ff - SLOT_BITS'(1);
   assign match  = mem_rdata == id_ff;

   always_ff @(posedge clock) begin
      if (cmd.cnt_load) begin
         n_ff <= cnt_rdata;
      end
      if (cmd.idx_clear) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff   <= idx_ff + SLOT_BITS'(1);
         found_ff <= found_ff | match;
      end
   end

   // member store: append on add, shift down behind the removed entry
   logic                 mem_we;
   logic [MEM_BITS-1:0]  mem_waddr;
   logic [ID_BITS-1:0]   mem_wdata;

   always_comb begin
      mem_we    = cmd.app_wr | (cmd.scan_step & cmd.shift_en & found_ff);
      mem_waddr = cmd.app_wr ? {cell_addr, n_ff[SLOT_BITS-1:0]} : {cell_addr, idx_m1};
      mem_wdata = cmd.app_wr ? id_ff : mem_rdata;
   end

   ugbt_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_SLOTS)) u_members (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr ({cell_addr, idx_ff}),
      .rdata (mem_rdata)
   );

   // output register
   logic                rsp_valid_ff;
   logic [ID_BITS-1:0]  rsp_id_ff;
   logic [2:0]          rsp_status_ff;
   logic                rsp_last_ff;
   logic [COL_BITS-1:0] rsp_col_ff;
   logic [ROW_BITS-1:0] rsp_row_ff;
   logic                out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         if (cmd.emit_status == ST_LISTED) rsp_id_ff <= mem_rdata;
         else if (cmd.emit_status == ST_EMPTY) rsp_id_ff <= '0;
         else rsp_id_ff <= id_ff;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
         rsp_col_ff    <= col_ff;
         rsp_row_ff    <= row_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_member_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_hit_col   = rsp_col_ff;
   assign rsp_hit_row   = rsp_row_ff;

   // status to controller
   always_comb begin
      sts.clr_done = clr_ff == '1;
      sts.div_done = div_cnt_ff == DIV_CNT_BITS'(POS_BITS - 1);
      sts.bad_cell = ({1'b0, col_ff} >= w_eff) | ({1'b0, row_ff} >= h_eff);
      sts.n_zero   = n_ff == '0;
      sts.n_full   = n_ff >= CNT_BITS'(CELL_CAPACITY);
      sts.idx_last = {1'b0, idx_ff} == (n_ff - CNT_BITS'(1));
      sts.found    = found_ff;
      sts.out_free = out_free;
   end

endmodule
`default_nettype wire

@@ hdl/ugbt_ctrl.sv @@
`default_nettype none
module ugbt_ctrl
   import ugbt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [1:0]   req_opcode,
   output logic              req_stall,
   input  wire ugbt_sts_type sts,
   output ugbt_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RM_CHK, S_DIV, S_MAP, S_CNT_RD, S_CNT_WAIT,
      S_BRANCH, S_SCAN_RD, S_SCAN_CHK, S_END, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [2:0] st_ff, st_in;

   assign req_stall = state_ff != S_IDLE;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               if (req_opcode == OP_ADD || req_opcode == OP_QUERY) state_in = S_DIV;
               else if (req_opcode == OP_REMOVE) state_in = S_RM_CHK;
            end
         end
         S_RM_CHK: begin
            if (sts.bad_cell) begin
               st_in    = ST_BAD_CELL;
               state_in = S_DONE;
            end else begin
               state_in = S_CNT_RD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_MAP;
         end
         S_MAP: begin
            cmd.map_load = 1'b1;
            state_in     = S_CNT_RD;
         end
         S_CNT_RD: state_in = S_CNT_WAIT;
         S_CNT_WAIT: begin
            cmd.cnt_load  = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in      = S_BRANCH;
         end
         S_BRANCH: begin
            if (!sts.n_zero) begin
               state_in = S_SCAN_RD;
            end else if (op_ff == OP_QUERY) begin
               st_in    = ST_EMPTY;
               state_in = S_DONE;
            end else if (op_ff == OP_REMOVE) begin
               st_in    = ST_NOT_PRESENT;
               state_in = S_DONE;
            end else begin
               state_in = S_END;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (op_ff == OP_QUERY) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_LISTED;
                  cmd.emit_last   = sts.idx_last;
                  cmd.scan_step   = 1'b1;
                  state_in        = sts.idx_last ? S_IDLE : S_SCAN_RD;
               end
            end else begin
               cmd.scan_step = 1'b1;
               cmd.shift_en  = op_ff == OP_REMOVE;
               state_in      = sts.idx_last ? S_END : S_SCAN_RD;
            end
         end
         S_END: begin
            state_in = S_DONE;
            if (op_ff == OP_REMOVE) begin
               if (sts.found) begin
                  cmd.cnt_wr = 1'b1;
                  st_in      = ST_REMOVED;
               end else begin
                  st_in = ST_NOT_PRESENT;
               end
            end else if (sts.found) begin
               st_in = ST_PRESENT;
            end else if (sts.n_full) begin
               st_in = ST_FULL;
            end else begin
               cmd.app_wr  = 1'b1;
               cmd.cnt_wr  = 1'b1;
               cmd.cnt_inc = 1'b1;
               st_in       = ST_ADDED;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = st_ff;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff    <= OP_ADD;
         st_ff    <= ST_ADDED;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         st_ff    <= st_in;
      end
   end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ugbt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 120;
   localparam int HOLD_CYCLES  = 600;

   typedef struct {
      logic [1:0]                op;
      logic signed [POS_BITS-1:0] px;
      logic signed [POS_BITS-1:0] py;
      logic [COL_BITS-1:0]       col;
      logic [ROW_BITS-1:0]       row;
      logic [ID_BITS-1:0]        id;
   } grid_op_type;

   typedef struct {
      logic [ID_BITS-1:0]  member;
      logic [2:0]          status;
      logic                last;
      logic [COL_BITS-1:0] hcol;
      logic [ROW_BITS-1:0] hrow;
   } grid_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_opcode = OP_ADD;
   logic signed [POS_BITS-1:0] req_pos_x = '0;
   logic signed [POS_BITS-1:0] req_pos_y = '0;
   logic [COL_BITS-1:0]        req_cell_col = '0;
   logic [ROW_BITS-1:0]        req_cell_row = '0;
   logic [ID_BITS-1:0]         req_entity_id = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [ID_BITS-1:0]         rsp_member_id;
   logic [2:0]                 rsp_status;
   logic                       rsp_last;
   logic [COL_BITS-1:0]        rsp_hit_col;
   logic [ROW_BITS-1:0]        rsp_hit_row;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [1:0]                 csr_index = CSR_CELL_SIZE;
   logic [SIZE_BITS-1:0]       csr_data = '0;

   uniform_grid_bucket_table_core uut (.*);

   // shadow of the grid
   logic [ID_BITS-1:0] grid_ids [NUM_CELLS][CELL_CAPACITY];
   int                 grid_cnt [NUM_CELLS];
   int                 cfg_cell_size = 8192;
   int                 cfg_width = 32;
   int                 cfg_height = 32;

   grid_op_type  pending_ops[$];
   grid_rsp_type expected_rsps[$];

   int send_idle_pct = 8;
   int recv_idle_pct = 73;
   int hold_left = 0;
   logic hold_start = 1'b0;
   int fail_count = 0;

   initial forever #5 clock = ~clock;

   function automatic int clamp_dim(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int axis_cell(logic signed [POS_BITS-1:0] p, int dim);
      int d;
      int q;
      d = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
      q = int'(p) / d;
      if (q < 0) return 0;
      if (q > dim - 1) return dim - 1;
      return q;
   endfunction

   function automatic void push_rsp(logic [ID_BITS-1:0] m, logic [2:0] s, logic l,
                                    int c, int r);
      grid_rsp_type e;
      e.member = m; e.status = s; e.last = l;
      e.hcol = COL_BITS'(c); e.hrow = ROW_BITS'(r);
      expected_rsps.insert(expected_rsps.size(), e);
   endfunction

   // works out the results of one accepted item and updates the shadow grid
   function automatic void predict_grid(grid_op_type it);
      int w;
      int h;
      int c;
      int r;
      int cell_idx;
      int n;
      int hit;
      w = clamp_dim(cfg_width, MAX_COLUMNS);
      h = clamp_dim(cfg_height, MAX_ROWS);
      if (it.op == OP_UNUSED) return;
      if (it.op == OP_REMOVE) begin
         c = it.col; r = it.row;
         if (c >= w || r >= h) begin
            push_rsp(it.id, ST_BAD_CELL, 1'b1, c, r);
            return;
         end
      end else begin
         c = axis_cell(it.px, w);
         r = axis_cell(it.py, h);
      end
      cell_idx = r * MAX_COLUMNS + c;
      n = grid_cnt[cell_idx];
      hit = -1;
      for (int i = 0; i < n; i++)
         if (grid_ids[cell_idx][i] == it.id) hit = i;
      case (it.op)
         OP_REMOVE: begin
            if (hit < 0) begin
               push_rsp(it.id, ST_NOT_PRESENT, 1'b1, c, r);
            end else begin
               for (int i = hit; i + 1 < n; i++)
                  grid_ids[cell_idx][i] = grid_ids[cell_idx][i+1];
               grid_cnt[cell_idx] = n - 1;
               push_rsp(it.id, ST_REMOVED, 1'b1, c, r);
            end
         end
         OP_ADD: begin
            if (hit >= 0) begin
               push_rsp(it.id, ST_PRESENT, 1'b1, c, r);
            end else if (n >= CELL_CAPACITY) begin
               push_rsp(it.id, ST_FULL, 1'b1, c, r);
            end else begin
               grid_ids[cell_idx][n] = it.id;
               grid_cnt[cell_idx] = n + 1;
               push_rsp(it.id, ST_ADDED, 1'b1, c, r);
            end
         end
         default: begin
            if (n == 0) push_rsp('0, ST_EMPTY, 1'b1, c, r);
            for (int i = 0; i < n; i++)
               push_rsp(grid_ids[cell_idx][i], ST_LISTED, i + 1 == n, c, r);
         end
      endcase
   endfunction

   // driver: predicts on acceptance, then offers the next pending item or idles
   always @(posedge clock) begin
      grid_op_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            it.op = req_opcode; it.px = req_pos_x; it.py = req_pos_y;
            it.col = req_cell_col; it.row = req_cell_row; it.id = req_entity_id;
            predict_grid(it);
         end
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_ops.pop_front();
            req_opcode <= it.op; req_pos_x <= it.px; req_pos_y <= it.py;
            req_cell_col <= it.col; req_cell_row <= it.row; req_entity_id <= it.id;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_left > 1) || hold_start || ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      grid_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: id %0d status %0d last %0d cell %0d,%0d",
                        rsp_member_id, rsp_status, rsp_last, rsp_hit_col, rsp_hit_row);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_member_id !== e.member || rsp_status !== e.status ||
                rsp_last !== e.last || rsp_hit_col !== e.hcol || rsp_hit_row !== e.hrow) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: exp id %0d st %0d last %0d cell %0d,%0d",
                            " / got id %0d st %0d last %0d cell %0d,%0d"},
                           e.member, e.status, e.last, e.hcol, e.hrow, rsp_member_id,
                           rsp_status, rsp_last, rsp_hit_col, rsp_hit_row);
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= SIZE_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CELL_SIZE:  cfg_cell_size = value & 16'hFFFF;
         CSR_GRID_WIDTH: cfg_width = value & 6'h3F;
         default:        cfg_height = value & 6'h3F;
      endcase
   endtask

   task automatic set_grid(int cs, int w, int h);
      write_reg(CSR_CELL_SIZE, cs);
      write_reg(CSR_GRID_WIDTH, w);
      write_reg(CSR_GRID_HEIGHT, h);
   endtask

   // waits until every item is taken and every result seen, then lets it settle
   task automatic wait_idle();
      while (pending_ops.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_op(logic [1:0] op, int px, int py, int c, int r, int id);
      grid_op_type it;
      it.op = op; it.px = POS_BITS'(px); it.py = POS_BITS'(py);
      it.col = COL_BITS'(c); it.row = ROW_BITS'(r); it.id = ID_BITS'(id);
      pending_ops.insert(pending_ops.size(), it);
   endtask

   // position that lands in a given cell index under the current cell size
   function automatic int pos_in(int idx);
      longint d;
      longint v;
      d = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
      v = longint'(idx) * d + $urandom_range(int'(d) - 1);
      if (v > 8388607) v = 8388607;
      return int'(v);
   endfunction

   // mostly ops on a few cells with a small id pool, some full-range noise
   task automatic random_ops(int count);
      int k;
      int px;
      int py;
      int id;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         px = (k < 15) ? int'($urandom) : pos_in($urandom_range(3));
         py = (k < 15) ? int'($urandom) : pos_in($urandom_range(2));
         id = ($urandom_range(9) == 0) ? int'($urandom) : $urandom_range(19);
         k = $urandom_range(99);
         if (k < 45)      add_op(OP_ADD, px, py, 0, 0, id);
         else if (k < 70) add_op(OP_REMOVE, 0, 0, ($urandom_range(4) == 0) ?
                                 $urandom_range(31) : $urandom_range(3),
                                 ($urandom_range(4) == 0) ? $urandom_range(31) :
                                 $urandom_range(2), id);
         else if (k < 97) add_op(OP_QUERY, px, py, 0, 0, 0);
         else             add_op(OP_UNUSED, px, py, $urandom_range(31),
                                 $urandom_range(31), id);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_CELLS; i++) grid_cnt[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and every status but full and bad cell under reset geometry
      add_op(OP_QUERY, 0, 0, 0, 0, 0);
      add_op(OP_ADD, 0, 0, 0, 0, 16'hFFFF);
      add_op(OP_ADD, 100, 200, 0, 0, 0);
      add_op(OP_ADD, 0, 0, 0, 0, 16'hFFFF);
      add_op(OP_ADD, -8388608, -8388608, 0, 0, 7);
      add_op(OP_ADD, 8388607, 8388607, 0, 0, 16'hA5A5);
      add_op(OP_ADD, 8388607, -1, 0, 0, 16'h5A5A);
      add_op(OP_QUERY, -5, -5, 0, 0, 0);
      add_op(OP_QUERY, 8388607, 8388607, 0, 0, 0);
      add_op(OP_REMOVE, 0, 0, 0, 0, 0);
      add_op(OP_REMOVE, 0, 0, 0, 0, 0);
      add_op(OP_REMOVE, 0, 0, 31, 31, 16'hA5A5);
      add_op(OP_QUERY, 0, 0, 0, 0, 0);
      add_op(OP_UNUSED, 8388607, -8388608, 31, 31, 16'hFFFF);
      add_op(OP_QUERY, 8388607, 8388607, 0, 0, 0);
      wait_idle();

      // fill one cell past capacity, then list it and remove from the middle
      set_grid(1, 0, 40);
      for (int i = 0; i < CELL_CAPACITY + 1; i++) add_op(OP_ADD, 0, 0, 0, 0, 100 + i);
      add_op(OP_QUERY, -3, 0, 0, 0, 0);
      add_op(OP_REMOVE, 0, 0, 0, 0, 105);
      add_op(OP_REMOVE, 0, 0, 1, 0, 105);
      add_op(OP_QUERY, 0, 0, 0, 0, 0);
      random_ops(60);
      wait_idle();

      set_grid(65535, 1, 1);
      random_ops(50);
      wait_idle();

      send_idle_pct = 73; recv_idle_pct = 8;
      set_grid(0, 63, 5);
      random_ops(60);
      wait_idle();

      set_grid(256, 4, 3);
      random_ops(80);
      wait_idle();

      // receiver holds off while the sender keeps offering
      send_idle_pct = 0; recv_idle_pct = 0;
      set_grid(8192, 32, 32);
      random_ops(90);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      wait_idle();

      set_grid(300, 3, 32);
      random_ops(60);
      wait_idle();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ugbt_pkg.sv
hdl/ugbt_ram.sv
hdl/ugbt_datapath.sv
hdl/ugbt_ctrl.sv
hdl/uniform_grid_bucket_table_core.sv
tb/tb_top.sv
